>>> sv/jnl_pkg.sv
package jnl_pkg;

   // Width of the saturating character counter.
   localparam int LEN_WIDTH = 16;
   // Width of the reported token length.
   localparam int OUT_LEN_WIDTH = 16;

   // Parser state codes.
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MINUS   = 4'd1;
   localparam logic [3:0] ST_ZERO    = 4'd2;
   localparam logic [3:0] ST_INT     = 4'd3;
   localparam logic [3:0] ST_DOT     = 4'd4;
   localparam logic [3:0] ST_FRAC    = 4'd5;
   localparam logic [3:0] ST_EXP     = 4'd6;
   localparam logic [3:0] ST_EXPSIGN = 4'd7;
   localparam logic [3:0] ST_EXPDIG  = 4'd8;
   localparam logic [3:0] ST_SWALLOW = 4'd9;

   // Error cause codes.
   localparam logic [2:0] CAUSE_NONE    = 3'd0;
   localparam logic [2:0] CAUSE_LEAD0   = 3'd1;
   localparam logic [2:0] CAUSE_NODIGIT = 3'd2;
   localparam logic [2:0] CAUSE_DOT     = 3'd3;
   localparam logic [2:0] CAUSE_EXP     = 3'd4;
   localparam logic [2:0] CAUSE_TAIL    = 3'd5;

   // Request command codes.
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_EOT  = 1'b1;

   // Characters with a role in the grammar.
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LOW_E = 8'h65;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;

   // Parser context carried from one character to the next.
   typedef struct packed {
      logic [3:0]           parse_state;
      logic [LEN_WIDTH-1:0] char_count;
      logic [2:0]           pending_cause;
   } ctx_type;

   // One result of the lexer.
   typedef struct packed {
      logic                     consumed;
      logic                     token_done;
      logic                     token_kind;
      logic [2:0]               error_cause;
      logic [OUT_LEN_WIDTH-1:0] token_length;
   } result_type;

endpackage

>>> sv/jnl_if.sv
// Request channel: one character or end-of-text mark.
interface jnl_req_if
   import jnl_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] ch;

   modport source (output valid, output cmd, output ch, input ready);
   modport sink (input valid, input cmd, input ch, output ready);
endinterface

// Response channel: one lexer result per request.
interface jnl_rsp_if
   import jnl_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     consumed;
   logic                     token_done;
   logic                     token_kind;
   logic [2:0]               error_cause;
   logic [OUT_LEN_WIDTH-1:0] token_length;

   modport source (output valid, output consumed, output token_done, output token_kind,
                   output error_cause, output token_length, input ready);
   modport sink (input valid, input consumed, input token_done, input token_kind,
                 input error_cause, input token_length, output ready);
endinterface

>>> sv/json_number_lexer.sv
// Streaming lexer for one JSON number token at a time, one request per clock.
// Each request carries a character or an end-of-text mark and yields exactly one
// response, in order, from a registered output stage. The parser state
// lives in a single register that the next request sees at once, so requests may
// arrive back to back at one per cycle; a two-entry output stage (result register
// plus skid register) lets a request be taken while a result waits, and req.ready
// drops only when both entries are full. A response with consumed low has not
// used its character: send that character again as the start of the next token.
module json_number_lexer
   import jnl_pkg::*;
(
   input logic      clock,
   input logic      reset,
   jnl_req_if.sink  req_chan,
   jnl_rsp_if.source rsp_chan
);

   ctx_type    ctx_ff;
   ctx_type    ctx_in;
   result_type step_result;
   result_type out_ff;
   result_type out_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type skid_ff;
   result_type skid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   ctx_type    step_ctx;
   logic       req_take;
   logic       rsp_take;

   assign req_chan.ready = !skid_valid_ff;
   assign req_take       = req_chan.valid && !skid_valid_ff;
   assign rsp_take       = out_valid_ff && rsp_chan.ready;

   // Grammar step for the incoming request.
   jnl_step u_step (
      .ctx      (ctx_ff),
      .cmd      (req_chan.cmd),
      .ch       (req_chan.ch),
      .ctx_next (step_ctx),
      .result   (step_result)
   );

   assign ctx_in = req_take ? step_ctx : ctx_ff;

   // Output register and skid entry.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = step_result;
            out_valid_in = req_take;
         end
      end else if (req_take) begin
         skid_in       = step_result;
         skid_valid_in = 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         ctx_ff        <= ctx_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.consumed     = out_ff.consumed;
   assign rsp_chan.token_done   = out_ff.token_done;
   assign rsp_chan.token_kind   = out_ff.token_kind;
   assign rsp_chan.error_cause  = out_ff.error_cause;
   assign rsp_chan.token_length = out_ff.token_length;

endmodule

>>> sv/jnl_step.sv
// Next-state and result logic for one request of the number lexer.
module jnl_step
   import jnl_pkg::*;
(
   input  ctx_type    ctx,
   input  logic       cmd,
   input  logic [7:0] ch,
   output ctx_type    ctx_next,
   output result_type result
);

   logic [3:0]           eff_state;
   logic                 is_digit;
   logic                 is_alpha;
   logic                 is_e;
   logic                 do_take;
   logic                 do_finish;
   logic                 fin_took;
   logic [2:0]           fin_cause;
   logic [3:0]           take_state;
   logic [2:0]           take_pending;
   logic [LEN_WIDTH-1:0] count_sat;
   logic [LEN_WIDTH-1:0] fin_count;
   logic [31:0]          fin_count_wide;

   // Character classes.
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_alpha = ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z)) ||
                     ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
   assign is_e     = (ch == CH_LOW_E) || (ch == CH_UP_E);

   // Unused state codes act as idle.
   assign eff_state = (ctx.parse_state > ST_SWALLOW) ? ST_IDLE : ctx.parse_state;

   // Saturating increment of the character count.
   assign count_sat = (ctx.char_count == {LEN_WIDTH{1'b1}}) ?
                      ctx.char_count : ctx.char_count + LEN_WIDTH'(1);

   // Take the character or finish the token; idle EOT does neither.
   always_comb begin
      do_take      = 1'b0;
      do_finish    = 1'b0;
      fin_took     = 1'b0;
      fin_cause    = CAUSE_NONE;
      take_state   = ST_IDLE;
      take_pending = ctx.pending_cause;
      if (cmd == CMD_EOT) begin
         do_finish = 1'b1;
         unique case (eff_state)
            ST_MINUS: fin_cause = CAUSE_NODIGIT;
            ST_ZERO, ST_INT, ST_FRAC, ST_EXPDIG: fin_cause = CAUSE_NONE;
            ST_DOT: fin_cause = CAUSE_DOT;
            ST_EXP, ST_EXPSIGN: fin_cause = CAUSE_EXP;
            ST_SWALLOW: fin_cause = ctx.pending_cause;
            default: do_finish = 1'b0;
         endcase
      end else begin
         unique case (eff_state)
            ST_ZERO, ST_INT: begin
               if (is_digit) begin
                  do_take = 1'b1;
                  if (eff_state == ST_INT) begin
                     take_state = ST_INT;
                  end else begin
                     take_state   = ST_SWALLOW;
                     take_pending = CAUSE_LEAD0;
                  end
               end else if (ch == CH_DOT) begin
                  do_take    = 1'b1;
                  take_state = ST_DOT;
               end else if (is_e) begin
                  do_take    = 1'b1;
                  take_state = ST_EXP;
               end else if (is_alpha || ch == CH_UNDER) begin
                  do_take      = 1'b1;
                  take_state   = ST_SWALLOW;
                  take_pending = CAUSE_TAIL;
               end else begin
                  do_finish = 1'b1;
               end
            end
            ST_DOT: begin
               if (is_digit) begin
                  do_take    = 1'b1;
                  take_state = ST_FRAC;
               end else begin
                  do_finish = 1'b1;
                  fin_cause = CAUSE_DOT;
               end
            end
            ST_FRAC: begin
               if (is_digit) begin
                  do_take    = 1'b1;
                  take_state = ST_FRAC;
               end else if (is_e) begin
                  do_take    = 1'b1;
                  take_state = ST_EXP;
               end else if (is_alpha || ch == CH_UNDER) begin
                  do_take      = 1'b1;
                  take_state   = ST_SWALLOW;
                  take_pending = CAUSE_TAIL;
               end else begin
                  do_finish = 1'b1;
               end
            end
            ST_EXP: begin
               if (ch == CH_PLUS || ch == CH_MINUS) begin
                  do_take    = 1'b1;
                  take_state = ST_EXPSIGN;
               end else if (is_digit) begin
                  do_take    = 1'b1;
                  take_state = ST_EXPDIG;
               end else begin
                  do_finish = 1'b1;
                  fin_cause = CAUSE_EXP;
               end
            end
            ST_EXPSIGN: begin
               if (is_digit) begin
                  do_take    = 1'b1;
                  take_state = ST_EXPDIG;
               end else begin
                  do_finish = 1'b1;
                  fin_cause = CAUSE_EXP;
               end
            end
            ST_EXPDIG: begin
               if (is_digit) begin
                  do_take    = 1'b1;
                  take_state = ST_EXPDIG;
               end else if (is_alpha || ch == CH_UNDER) begin
                  do_take      = 1'b1;
                  take_state   = ST_SWALLOW;
                  take_pending = CAUSE_TAIL;
               end else begin
                  do_finish = 1'b1;
               end
            end
            ST_SWALLOW: begin
               if (is_digit || is_alpha ||
                   (ch == CH_UNDER && ctx.pending_cause == CAUSE_TAIL)) begin
                  do_take    = 1'b1;
                  take_state = ST_SWALLOW;
               end else begin
                  do_finish = 1'b1;
                  fin_cause = ctx.pending_cause;
               end
            end
            default: begin
               // Idle or after a minus sign.
               if (eff_state == ST_IDLE && ch == CH_MINUS) begin
                  do_take    = 1'b1;
                  take_state = ST_MINUS;
               end else if (ch == CH_ZERO) begin
                  do_take    = 1'b1;
                  take_state = ST_ZERO;
               end else if (is_digit) begin
                  do_take    = 1'b1;
                  take_state = ST_INT;
               end else begin
                  do_finish = 1'b1;
                  fin_took  = 1'b1;
                  fin_cause = CAUSE_NODIGIT;
               end
            end
         endcase
      end
   end

   // A consumed final character counts toward the reported length.
   assign fin_count      = fin_took ? count_sat : ctx.char_count;
   assign fin_count_wide = 32'(fin_count);

   // Build the next context and the result.
   always_comb begin
      ctx_next = '0;
      result   = '0;
      if (do_take) begin
         ctx_next.parse_state   = take_state;
         ctx_next.char_count    = count_sat;
         ctx_next.pending_cause = take_pending;
         result.consumed        = 1'b1;
      end else if (do_finish) begin
         result.consumed     = fin_took;
         result.token_done   = 1'b1;
         result.token_kind   = (fin_cause != CAUSE_NONE);
         result.error_cause  = fin_cause;
         result.token_length = (fin_count_wide > 32'({OUT_LEN_WIDTH{1'b1}})) ?
                               {OUT_LEN_WIDTH{1'b1}} : fin_count_wide[OUT_LEN_WIDTH-1:0];
      end
   end

endmodule

>>> sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import jnl_pkg::*;

   // Cycles without any request or response accepted before the run is abandoned.
   localparam int STALL_LIMIT = 5000;
   // Least number of requests per pacing phase of the random part.
   localparam int PHASE_REQUESTS = 475;
   localparam longint unsigned LEN_OUT_MAX = (64'd1 << OUT_LEN_WIDTH) - 64'd1;

   // One row of the directed opening; rsp is only used when typed is set.
   typedef struct {
      logic       cmd;
      logic [7:0] ch;
      logic       typed;
      result_type rsp;
   } lex_row_type;

   logic clock = 1'b0;
   logic reset;
   logic rsp_ready = 1'b0;

   jnl_req_if req_if();
   jnl_rsp_if rsp_if();

   json_number_lexer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   assign rsp_if.ready = rsp_ready;

   // Shadow copy of the parser context.
   logic [3:0]           lex_state = ST_IDLE;
   logic [LEN_WIDTH-1:0] lex_count = '0;
   logic [2:0]           lex_cause = CAUSE_NONE;

   result_type  lex_results_q[$];
   lex_row_type lex_rows[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int requests = 0;
   int tokens_done = 0;
   int tokens_bad = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   // Delimiters that commonly follow a number in JSON text.
   logic [7:0] delims [6] = '{8'h20, 8'h2C, 8'h5D, 8'h7D, 8'h0A, 8'h09};

   always #5 clock = ~clock;

   // The receiver drops ready at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Advances the shadow context by one request and returns the result it must produce.
   function automatic result_type lex_char(input logic cmd, input logic [7:0] ch);
      result_type r;
      logic [3:0] st, nx;
      logic [2:0] cause, next_cause;
      logic       dig, tail, stay, ends, took;
      longint unsigned n;
      r = '0;
      st = (lex_state > ST_SWALLOW) ? ST_IDLE : lex_state;
      dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
      tail = ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z)) || ((ch >= CH_UP_A) && (ch <= CH_UP_Z))
             || (ch == CH_UNDER);
      nx = ST_IDLE;
      cause = CAUSE_NONE;
      next_cause = lex_cause;
      stay = 1'b0;
      ends = 1'b0;
      took = 1'b0;
      if (cmd == CMD_EOT) begin
         // End of text closes any open token without consuming anything.
         ends = (st != ST_IDLE);
         case (st)
            ST_MINUS: cause = CAUSE_NODIGIT;
            ST_DOT: cause = CAUSE_DOT;
            ST_EXP, ST_EXPSIGN: cause = CAUSE_EXP;
            ST_SWALLOW: cause = lex_cause;
            default: cause = CAUSE_NONE;
         endcase
      end else begin
         case (st)
            ST_ZERO, ST_INT: begin
               if (dig) begin
                  stay = 1'b1;
                  if (st == ST_INT) begin
                     nx = ST_INT;
                  end else begin
                     nx = ST_SWALLOW;
                     next_cause = CAUSE_LEAD0;
                  end
               end else if (ch == CH_DOT) begin
                  stay = 1'b1;
                  nx = ST_DOT;
               end else if (ch == CH_LOW_E || ch == CH_UP_E) begin
                  stay = 1'b1;
                  nx = ST_EXP;
               end else if (tail) begin
                  stay = 1'b1;
                  nx = ST_SWALLOW;
                  next_cause = CAUSE_TAIL;
               end else begin
                  ends = 1'b1;
               end
            end
            ST_DOT: begin
               stay = dig;
               nx = ST_FRAC;
               ends = !dig;
               cause = CAUSE_DOT;
            end
            ST_FRAC: begin
               if (dig) begin
                  stay = 1'b1;
                  nx = ST_FRAC;
               end else if (ch == CH_LOW_E || ch == CH_UP_E) begin
                  stay = 1'b1;
                  nx = ST_EXP;
               end else if (tail) begin
                  stay = 1'b1;
                  nx = ST_SWALLOW;
                  next_cause = CAUSE_TAIL;
               end else begin
                  ends = 1'b1;
               end
            end
            ST_EXP: begin
               if (ch == CH_PLUS || ch == CH_MINUS) begin
                  stay = 1'b1;
                  nx = ST_EXPSIGN;
               end else if (dig) begin
                  stay = 1'b1;
                  nx = ST_EXPDIG;
               end else begin
                  ends = 1'b1;
                  cause = CAUSE_EXP;
               end
            end
            ST_EXPSIGN: begin
               stay = dig;
               nx = ST_EXPDIG;
               ends = !dig;
               cause = CAUSE_EXP;
            end
            ST_EXPDIG: begin
               if (dig) begin
                  stay = 1'b1;
                  nx = ST_EXPDIG;
               end else if (tail) begin
                  stay = 1'b1;
                  nx = ST_SWALLOW;
                  next_cause = CAUSE_TAIL;
               end else begin
                  ends = 1'b1;
               end
            end
            ST_SWALLOW: begin
               // The underscore only continues an alpha tail, not a leading-zero run.
               if (dig || (tail && ch != CH_UNDER) || (ch == CH_UNDER && lex_cause == CAUSE_TAIL))
               begin
                  stay = 1'b1;
                  nx = ST_SWALLOW;
               end else begin
                  ends = 1'b1;
                  cause = lex_cause;
               end
            end
            default: begin
               // Idle, or after a lone minus: a number must start with a digit.
               if (st == ST_IDLE && ch == CH_MINUS) begin
                  stay = 1'b1;
                  nx = ST_MINUS;
               end else if (ch == CH_ZERO) begin
                  stay = 1'b1;
                  nx = ST_ZERO;
               end else if (dig) begin
                  stay = 1'b1;
                  nx = ST_INT;
               end else begin
                  took = 1'b1;
                  ends = 1'b1;
                  cause = CAUSE_NODIGIT;
               end
            end
         endcase
      end

      // The length counter saturates rather than wrapping.
      if ((stay || took) && lex_count != '1) begin
         lex_count = lex_count + 1'b1;
      end
      if (stay) begin
         r.consumed = 1'b1;
         lex_state = nx;
         lex_cause = next_cause;
      end else begin
         if (ends) begin
            n = 64'(lex_count);
            if (n > LEN_OUT_MAX) begin
               n = LEN_OUT_MAX;
            end
            r.consumed = took;
            r.token_done = 1'b1;
            r.token_kind = (cause != CAUSE_NONE);
            r.error_cause = cause;
            r.token_length = n[OUT_LEN_WIDTH-1:0];
         end
         lex_state = ST_IDLE;
         lex_count = '0;
         lex_cause = CAUSE_NONE;
      end
      return r;
   endfunction

   function automatic result_type rsp_of(input logic took, input logic done, input logic bad,
                                         input logic [2:0] cause, input int len);
      result_type r;
      r.consumed = took;
      r.token_done = done;
      r.token_kind = bad;
      r.error_cause = cause;
      r.token_length = len[OUT_LEN_WIDTH-1:0];
      return r;
   endfunction

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // A character that may appear inside a swallowed word: letter, digit or underscore.
   function automatic logic [7:0] rand_word_char();
      case ($urandom_range(0, 3))
         0: return rand_digit();
         1: return CH_LOW_A + 8'($urandom_range(0, 25));
         2: return CH_UP_A + 8'($urandom_range(0, 25));
         default: return CH_UNDER;
      endcase
   endfunction

   function automatic void report_mismatch(input string what, input result_type want,
                                           input result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("[%0t] %s: expected consumed=%0d done=%0d kind=%0d cause=%0d len=%0d",
                  $realtime, what, want.consumed, want.token_done, want.token_kind,
                  want.error_cause, want.token_length);
         $display("[%0t] %s:      got consumed=%0d done=%0d kind=%0d cause=%0d len=%0d",
                  $realtime, what, got.consumed, got.token_done, got.token_kind,
                  got.error_cause, got.token_length);
      end
   endfunction

   // Response checking and the stall watchdog.
   always @(posedge clock) begin : rsp_check
      result_type got, want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.consumed, rsp_if.token_done, rsp_if.token_kind,
                   rsp_if.error_cause, rsp_if.token_length};
            if (got.token_done) begin
               tokens_done++;
               tokens_bad += got.token_kind;
            end
            if (lex_results_q.size() == 0) begin
               report_mismatch("response with no request outstanding", '0, got);
            end else begin
               want = lex_results_q.pop_front();
               if (got.consumed !== want.consumed || got.token_done !== want.token_done ||
                   got.token_kind !== want.token_kind ||
                   got.error_cause !== want.error_cause ||
                   got.token_length !== want.token_length) begin
                  report_mismatch("response mismatch", want, got);
               end
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timed out: %0d responses still outstanding", lex_results_q.size());
            $display("FAIL json_number_lexer");
            $finish;
         end
      end
   end

   // Offers one request, waits for it to be taken and records what it must return.
   task automatic send_request(input logic cmd, input logic [7:0] ch, input logic use_typed,
                               input result_type typed_rsp, output result_type predicted);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.ch <= ch;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = lex_char(cmd, ch);
      lex_results_q.insert(lex_results_q.size(), use_typed ? typed_rsp : predicted);
      requests++;
   endtask

   // Sends like a real caller: a character that was not consumed is offered again.
   task automatic feed(input logic cmd, input logic [7:0] ch);
      result_type r;
      send_request(cmd, ch, 1'b0, '0, r);
      if (cmd == CMD_CHAR && !r.consumed) begin
         send_request(cmd, ch, 1'b0, '0, r);
      end
   endtask

   task automatic put_int();
      int len;
      if ($urandom_range(0, 4) == 0) begin
         feed(CMD_CHAR, CH_ZERO);
      end else begin
         feed(CMD_CHAR, CH_ZERO + 8'($urandom_range(1, 9)));
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 4);
         repeat (len) feed(CMD_CHAR, rand_digit());
      end
   endtask

   task automatic put_frac();
      feed(CMD_CHAR, CH_DOT);
      repeat ($urandom_range(1, 4)) feed(CMD_CHAR, rand_digit());
   endtask

   // Exponent marker, optional sign and up to max_digits digits; none makes it bare.
   task automatic put_exp(input int max_digits);
      feed(CMD_CHAR, $urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
      if ($urandom_range(0, 1)) begin
         feed(CMD_CHAR, $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      end
      if (max_digits > 0) begin
         repeat ($urandom_range(1, max_digits)) feed(CMD_CHAR, rand_digit());
      end
   endtask

   // Whatever follows a token: end of text, a delimiter or any byte at all.
   task automatic end_token();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         feed(CMD_EOT, 8'($urandom_range(0, 255)));
      end else if (pick < 6) begin
         feed(CMD_CHAR, delims[$urandom_range(0, 5)]);
      end else begin
         feed(CMD_CHAR, 8'($urandom_range(0, 255)));
      end
   endtask

   // One token, mostly well formed, otherwise one of the malformed shapes or noise.
   task automatic gen_token();
      int shape;
      shape = $urandom_range(0, 99);
      if (shape < 60) begin
         if ($urandom_range(0, 2) == 0) feed(CMD_CHAR, CH_MINUS);
         put_int();
         if ($urandom_range(0, 1)) put_frac();
         if ($urandom_range(0, 2) == 0) put_exp(3);
         end_token();
      end else if (shape < 70) begin
         // Leading zero followed by a digit; the rest of the word is swallowed.
         if ($urandom_range(0, 1)) feed(CMD_CHAR, CH_MINUS);
         feed(CMD_CHAR, CH_ZERO);
         feed(CMD_CHAR, rand_digit());
         repeat ($urandom_range(0, 5)) feed(CMD_CHAR, rand_word_char());
         end_token();
      end else if (shape < 76) begin
         feed(CMD_CHAR, CH_MINUS);
         end_token();
      end else if (shape < 82) begin
         put_int();
         feed(CMD_CHAR, CH_DOT);
         end_token();
      end else if (shape < 88) begin
         put_int();
         if ($urandom_range(0, 1)) put_frac();
         put_exp(0);
         end_token();
      end else if (shape < 95) begin
         // A complete number running straight into a word.
         put_int();
         if ($urandom_range(0, 1)) put_frac();
         if ($urandom_range(0, 1)) put_exp(2);
         feed(CMD_CHAR, $urandom_range(0, 3) == 0 ? CH_UNDER : CH_LOW_A + 8'($urandom_range(0, 25)));
         repeat ($urandom_range(0, 5)) feed(CMD_CHAR, rand_word_char());
         end_token();
      end else begin
         repeat ($urandom_range(1, 4)) feed(CMD_CHAR, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) feed(CMD_EOT, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) feed(CMD_EOT, 8'($urandom_range(0, 255)));
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int base;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      base = requests;
      while (requests - base < PHASE_REQUESTS) gen_token();
      // Hold the sender off until every response so far has come back.
      req_if.valid <= 1'b0;
      do @(posedge clock); while (lex_results_q.size() != 0);
   endtask

   task automatic add_row(input logic cmd, input logic [7:0] ch, input logic typed,
                          input result_type rsp);
      lex_row_type row;
      row.cmd = cmd;
      row.ch = ch;
      row.typed = typed;
      row.rsp = rsp;
      lex_rows.insert(lex_rows.size(), row);
   endtask

   initial begin
      result_type r;
      req_if.valid <= 1'b0;
      req_if.cmd <= CMD_CHAR;
      req_if.ch <= '0;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // End of text while idle gives an all-zero result.
      add_row(CMD_EOT, 8'hFF, 1'b1, rsp_of(1'b0, 1'b0, 1'b0, CAUSE_NONE, 0));
      // Minus then a letter: no digit.
      add_row(CMD_CHAR, CH_MINUS, 1'b1, rsp_of(1'b1, 1'b0, 1'b0, CAUSE_NONE, 0));
      add_row(CMD_CHAR, 8'h78, 1'b1, rsp_of(1'b1, 1'b1, 1'b1, CAUSE_NODIGIT, 2));
      // Leading zero, swallowed letter, ended by a space that is then offered again.
      add_row(CMD_CHAR, CH_ZERO, 1'b0, '0);
      add_row(CMD_CHAR, CH_ZERO + 8'd7, 1'b0, '0);
      add_row(CMD_CHAR, CH_LOW_Z, 1'b0, '0);
      add_row(CMD_CHAR, 8'h20, 1'b1, rsp_of(1'b0, 1'b1, 1'b1, CAUSE_LEAD0, 3));
      add_row(CMD_CHAR, 8'h20, 1'b1, rsp_of(1'b1, 1'b1, 1'b1, CAUSE_NODIGIT, 1));
      // Bare dot closed by end of text.
      add_row(CMD_CHAR, CH_NINE, 1'b0, '0);
      add_row(CMD_CHAR, CH_DOT, 1'b0, '0);
      add_row(CMD_EOT, 8'h00, 1'b1, rsp_of(1'b0, 1'b1, 1'b1, CAUSE_DOT, 2));
      // Full number with signed exponent, then an alpha tail.
      add_row(CMD_CHAR, CH_ZERO + 8'd1, 1'b0, '0);
      add_row(CMD_CHAR, CH_DOT, 1'b0, '0);
      add_row(CMD_CHAR, CH_ZERO + 8'd5, 1'b0, '0);
      add_row(CMD_CHAR, CH_UP_E, 1'b0, '0);
      add_row(CMD_CHAR, CH_PLUS, 1'b0, '0);
      add_row(CMD_CHAR, CH_ZERO + 8'd8, 1'b0, '0);
      add_row(CMD_CHAR, CH_UNDER, 1'b0, '0);
      add_row(CMD_CHAR, CH_UP_A, 1'b0, '0);
      add_row(CMD_CHAR, 8'hFF, 1'b1, rsp_of(1'b0, 1'b1, 1'b1, CAUSE_TAIL, 8));
      // High and low bytes at the start are neither digits nor letters.
      add_row(CMD_CHAR, 8'hFF, 1'b1, rsp_of(1'b1, 1'b1, 1'b1, CAUSE_NODIGIT, 1));
      add_row(CMD_CHAR, 8'h00, 1'b1, rsp_of(1'b1, 1'b1, 1'b1, CAUSE_NODIGIT, 1));
      // Bare exponent closed by end of text.
      add_row(CMD_CHAR, CH_ZERO + 8'd3, 1'b0, '0);
      add_row(CMD_CHAR, CH_LOW_E, 1'b0, '0);
      add_row(CMD_EOT, 8'h00, 1'b1, rsp_of(1'b0, 1'b1, 1'b1, CAUSE_EXP, 2));
      // Valid negative zero ended by a comma.
      add_row(CMD_CHAR, CH_MINUS, 1'b0, '0);
      add_row(CMD_CHAR, CH_ZERO, 1'b0, '0);
      add_row(CMD_CHAR, 8'h2C, 1'b1, rsp_of(1'b0, 1'b1, 1'b0, CAUSE_NONE, 2));
      foreach (lex_rows[i]) begin
         send_request(lex_rows[i].cmd, lex_rows[i].ch, lex_rows[i].typed, lex_rows[i].rsp, r);
      end

      run_phase(0, 0);
      run_phase(88, 0);
      run_phase(0, 88);
      run_phase(26, 26);

      repeat (10) @(posedge clock);
      $display("Lexed %0d requests: directed cases, then random tokens under four pacings",
               requests);
      $display("of sender and receiver; %0d tokens finished, %0d of them invalid.",
               tokens_done, tokens_bad);
      if (mismatches != 0) begin
         $display("%0d mismatches in all", mismatches);
      end
      if (mismatches == 0 && lex_results_q.size() == 0) begin
         $display("PASS json_number_lexer");
      end else begin
         $display("FAIL json_number_lexer");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/jnl_pkg.sv
sv/jnl_if.sv
sv/jnl_step.sv
sv/json_number_lexer.sv
sim/tb_top.sv
